[rtl/core/moving_average_filter_macros.svh]
// Assertion macros for the moving average filter checker.
// No dependencies; included by the checker file.
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

// Implication checked at every clock edge outside of reset.
`define MAF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/maf_pkg.sv]
// Package for the moving average filter: defaults, register constants,
// controller states and the command and status structs. No dependencies.
package maf_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int WINDOW_W = 7;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_EMIT
  } maf_state_t;

  typedef struct packed {
    logic capture;   // latch the sample and read the entry it replaces
    logic update;    // update the running sum, write the store, advance the index
    logic load;      // form the rounded numerator and load the divider
    logic div_step;  // one restoring division step
    logic emit;      // move the quotient into the output register
  } maf_cmd_t;

  typedef struct packed {
    logic div_done;  // the current step is the last quotient bit
    logic out_free;  // the output register can take a new result
  } maf_status_t;

endpackage

[rtl/core/moving_average_filter.sv]
// Top level of the boxcar moving average filter.
// Depends on maf_pkg, maf_ctrl, maf_datapath and maf_ram.
//
// Boxcar moving average over the last window_length converter samples. Each
// sample transaction on the s_ side yields exactly one average transaction on
// the m_ side: the running sum of the window divided by the effective window
// length and rounded half up. A window_length of zero acts as one, and values
// above MAX_WINDOW act as MAX_WINDOW. Reset and every write of the window
// register empty the window, so the first averages after either include zeros
// for entries not yet written. The block works on one sample at a time: an
// accepted sample passes through capture with the store read, the sum update
// with the store write, the divider load, the restoring division, which
// produces one quotient bit per cycle, and the hand-off of the result into
// the output register, which waits until the previous result has been
// taken. The next sample can be accepted only after that hand-off. A result
// waiting in the output register does not block the next sample from being
// accepted; only the hand-off of that next result waits for it. The window
// register must be written only while no transaction is in flight.
module moving_average_filter import maf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Window length register write port.
  input  logic                                cfg_we,
  input  logic [WINDOW_W-1:0]                 cfg_wdata,
  // Sample stream. s_tdata: sample, then zero padding.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  // Average stream. m_tdata: average, then zero padding.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  maf_cmd_t               cmd;
  maf_status_t            status;
  logic [SAMPLE_BITS-1:0] average;

  // The controller sequences one sample through the datapath.
  maf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Bits of s_tdata above the sample width are ignored.
  maf_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_sample   (s_tdata[SAMPLE_BITS-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_average (average)
  );

  assign m_tdata = DATA_W'(average);

endmodule

[rtl/core/maf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module maf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/maf_ctrl.sv]
// Controller state machine of the moving average filter.
// Depends on maf_pkg for the state type and the command and status structs.
module maf_ctrl import maf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  maf_status_t status,
  output maf_cmd_t    cmd
);

  maf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold here until the previous result has been taken.
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/maf_datapath.sv]
// Datapath of the moving average filter: window register, sample store,
// running sum, restoring divider and output register.
// Depends on maf_pkg and maf_ram.
module maf_datapath import maf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [WINDOW_W-1:0]    cfg_wdata,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  maf_cmd_t               cmd,
  output maf_status_t            status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [SAMPLE_BITS-1:0] out_average
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int NUM_W = SUM_W + 1;
  localparam int DEN_W = LEN_W + 1;
  localparam int REM_W = LEN_W + 2;
  localparam int CNT_W = $clog2(SAMPLE_BITS);
  localparam int CMP_W = (LEN_W > WINDOW_W) ? LEN_W : WINDOW_W;

  logic [WINDOW_W-1:0]    window;
  logic [LEN_W-1:0]       len;
  logic [IDX_W-1:0]       wr_index;
  logic                   filled;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [LEN_W-1:0]       idx_inc;
  logic [NUM_W-1:0]       numerator;
  logic [REM_W-1:0]       rem;
  logic [DEN_W-1:0]       den;
  logic [SAMPLE_BITS-1:0] quo;
  logic [CNT_W-1:0]       cnt;
  logic [REM_W-1:0]       trial;
  logic                   trial_ge;

  // Effective window length: zero acts as one, large values saturate.
  always_comb begin
    if (window == '0) begin
      len = LEN_W'(1);
    end else if (CMP_W'(window) > CMP_W'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(CMP_W'(window));
    end
  end

  maf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (wr_index),
    .wdata (sample_q),
    .re    (cmd.capture),
    .raddr (wr_index),
    .rdata (rd_data)
  );

  // The store fills in index order after a clear, so the entry under the
  // write index holds a real sample only once the index has wrapped.
  assign old_sample = filled ? rd_data : '0;
  assign idx_inc    = LEN_W'(wr_index) + LEN_W'(1);
  assign numerator  = {sum, 1'b0} + NUM_W'(len);
  assign trial      = {rem[REM_W-2:0], quo[SAMPLE_BITS-1]};
  assign trial_ge   = trial >= REM_W'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= WINDOW_RESET;
      sum      <= '0;
      wr_index <= '0;
      filled   <= 1'b0;
    end else if (cfg_we) begin
      window   <= cfg_wdata;
      sum      <= '0;
      wr_index <= '0;
      filled   <= 1'b0;
    end else if (cmd.update) begin
      sum <= sum - SUM_W'(old_sample) + SUM_W'(sample_q);
      if (idx_inc >= len) begin
        wr_index <= '0;
        filled   <= 1'b1;
      end else begin
        wr_index <= IDX_W'(idx_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= in_sample;
    end
    if (cmd.load) begin
      // The quotient fits in SAMPLE_BITS bits, so the high part of the
      // numerator already lies below the divisor.
      rem <= REM_W'(numerator[NUM_W-1:SAMPLE_BITS]);
      quo <= numerator[SAMPLE_BITS-1:0];
      den <= {len, 1'b0};
      cnt <= CNT_W'(SAMPLE_BITS - 1);
    end else if (cmd.div_step) begin
      rem <= trial_ge ? (trial - REM_W'(den)) : trial;
      quo <= {quo[SAMPLE_BITS-2:0], trial_ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.emit) begin
      out_average <= quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.div_done = (cnt == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

[rtl/core/maf_checker.sv]
// Port-level checker for the moving average filter, bound to the top level.
// Depends on maf_pkg and moving_average_filter_macros.svh.
`include "moving_average_filter_macros.svh"

module maf_checker import maf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

  // One sample at a time: the input closes right after a transaction.
  `MAF_ASSERT(a_one_in_flight, s_tvalid && s_tready, ##1 !s_tready, "input taken while busy")

  // Reset leaves no result pending.
  `MAF_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid, "result present after reset")

  // A stalled result stays offered.
  `MAF_ASSERT(a_out_hold, m_tvalid && !m_tready, ##1 m_tvalid, "result dropped")

  // A stalled result keeps its value.
  `MAF_ASSERT(a_out_stable, m_tvalid && !m_tready, ##1 $stable(m_tdata), "result changed")

endmodule

bind moving_average_filter maf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_maf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
